// File: sv/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and constants for the running median block
// Heap sizing defaults, field widths, the controller state encoding and the command and status structs.
// ----------------------------------------------------------------------------
package rmth_pkg;

   localparam int HalfCapacityDefault = 512;
   localparam int SampleWidthDefault  = 32;
   localparam int DataWidth           = 32;
   localparam int MedianWidth         = 33;
   localparam int CountWidth          = 11;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DN_READ,
      ST_DN_CMP,
      ST_PUSH,
      ST_UP_READ,
      ST_UP_CMP,
      ST_TOPS,
      ST_RESULT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // capture sample, read both tops
      logic decide;      // pick heaps and start the first sift
      logic dn_read;     // read children of the sift-down hole
      logic dn_step;     // compare children, move one up or finish
      logic push;        // append the crossing top to the other heap
      logic up_read;     // read parent of the sift-up hole
      logic up_step;     // compare parent, move it down or finish
      logic place;       // write the sifted value into the hole
      logic tops_read;   // read both heap tops
      logic result;      // build the result item
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic full;        // store full, drop the sample
      logic need_down;   // a replace-top sift-down is needed
      logic leaf;        // sift-down hole has no children
      logic at_root;     // sift-up hole is at the root
      logic dn_stop;     // sift-down ends at this compare
      logic up_stop;     // sift-up ends at this compare
   } status_type;

endpackage

// File: sv/rmth_stream_if.sv
// ----------------------------------------------------------------------------
// rmth_stream_if: valid/ready channel
// Carries one payload of the given width per accepted item.
// ----------------------------------------------------------------------------
interface rmth_stream_if #(
   parameter int Width = 32
);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/rmth_ctrl.sv
// ----------------------------------------------------------------------------
// rmth_ctrl: controller for the running median
// Sequences the sift-down and sift-up loops and the output handshake.
// ----------------------------------------------------------------------------
module rmth_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rmth_pkg::cmd_type       cmd,
   input  rmth_pkg::status_type    status
);

   rmth_pkg::state_type state_ff, state_in;
   logic                out_valid_ff, out_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmth_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   // the result register may hold while the next item is worked on
   assign in_ready  = (state_ff == rmth_pkg::ST_IDLE);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      out_valid_in = out_valid_ff & ~out_ready;
      case (state_ff)
         rmth_pkg::ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = rmth_pkg::ST_DECIDE;
            end
         end
         rmth_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.full)           state_in = rmth_pkg::ST_TOPS;
            else if (status.need_down) state_in = rmth_pkg::ST_DN_READ;
            else                       state_in = rmth_pkg::ST_UP_READ;
         end
         rmth_pkg::ST_DN_READ: begin
            if (status.leaf) begin
               cmd.place = 1'b1;
               state_in  = rmth_pkg::ST_PUSH;
            end else begin
               cmd.dn_read = 1'b1;
               state_in    = rmth_pkg::ST_DN_CMP;
            end
         end
         rmth_pkg::ST_DN_CMP: begin
            cmd.dn_step = 1'b1;
            if (status.dn_stop) state_in = rmth_pkg::ST_PUSH;
            else                state_in = rmth_pkg::ST_DN_READ;
         end
         rmth_pkg::ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = rmth_pkg::ST_UP_READ;
         end
         rmth_pkg::ST_UP_READ: begin
            if (status.at_root) begin
               cmd.place = 1'b1;
               state_in  = rmth_pkg::ST_TOPS;
            end else begin
               cmd.up_read = 1'b1;
               state_in    = rmth_pkg::ST_UP_CMP;
            end
         end
         rmth_pkg::ST_UP_CMP: begin
            cmd.up_step = 1'b1;
            if (status.up_stop) state_in = rmth_pkg::ST_TOPS;
            else                state_in = rmth_pkg::ST_UP_READ;
         end
         rmth_pkg::ST_TOPS: begin
            cmd.tops_read = 1'b1;
            state_in      = rmth_pkg::ST_RESULT;
         end
         rmth_pkg::ST_RESULT: begin
            // wait for the previous result to leave
            if (!out_valid_ff || out_ready) begin
               cmd.result   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = rmth_pkg::ST_IDLE;
            end
         end
         default: state_in = rmth_pkg::ST_IDLE;
      endcase
   end

   // a result is only loaded when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.result |-> (!out_valid_ff || out_ready))
      else $error("result overwritten");
   // an item is only taken in idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == rmth_pkg::ST_DECIDE)
      else $error("load outside idle");
   // a result follows the tops read
   a_tops_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.tops_read |=> state_ff == rmth_pkg::ST_RESULT)
      else $error("tops sequence broken");
   // a waiting result stays until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> out_valid_ff)
      else $error("result dropped while stalled");

endmodule

// File: sv/rmth_datapath.sv
// ----------------------------------------------------------------------------
// rmth_datapath: heaps, sizes and sift engine
// Two heap memories with registered reads at two addresses, one hole
// pointer shared by the sift-down and sift-up loops, and the result register.
// ----------------------------------------------------------------------------
module rmth_datapath #(
   parameter int HalfCapacity = rmth_pkg::HalfCapacityDefault,
   parameter int SampleWidth  = rmth_pkg::SampleWidthDefault
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic signed [SampleWidth-1:0]           sample,
   input  rmth_pkg::cmd_type                       cmd,
   output rmth_pkg::status_type                    status,
   output logic signed [rmth_pkg::MedianWidth-1:0] median_doubled,
   output logic [rmth_pkg::CountWidth-1:0]         held_count,
   output logic                                    dropped
);

   localparam int AddrWidth = (HalfCapacity > 1) ? $clog2(HalfCapacity) : 1;
   localparam int IdxWidth  = AddrWidth + 1;
   localparam int SizeWidth = $clog2(HalfCapacity + 1);
   localparam logic [SizeWidth-1:0] Cap = SizeWidth'(HalfCapacity);

   // true if a belongs nearer the top than b
   function automatic logic outranks(input logic signed [SampleWidth-1:0] a,
                                     input logic signed [SampleWidth-1:0] b,
                                     input logic                          is_max);
      outranks = is_max ? (a > b) : (a < b);
   endfunction

   logic signed [SampleWidth-1:0] lo_mem [HalfCapacity];
   logic signed [SampleWidth-1:0] hi_mem [HalfCapacity];

   logic [SizeWidth-1:0]          lo_size_ff, lo_size_in, hi_size_ff, hi_size_in;
   logic signed [SampleWidth-1:0] val_ff;                 // sample
   logic signed [SampleWidth-1:0] moved_ff, moved_in;     // top that crosses over
   logic signed [SampleWidth-1:0] cur_ff, cur_in;         // value being sifted
   logic [AddrWidth-1:0]          idx_ff, idx_in;         // hole position
   logic                          sel_ff, sel_in;         // 1: lower heap
   logic                          drop_ff, drop_in;
   logic                          has_r_ff;
   logic signed [SampleWidth-1:0] lo_ra_ff, lo_rb_ff, hi_ra_ff, hi_rb_ff;
   logic signed [rmth_pkg::MedianWidth-1:0] med_ff;
   logic [rmth_pkg::CountWidth-1:0]         cnt_ff;
   logic                                    dropped_ff;

   // hole neighbors
   logic [IdxWidth-1:0]  left_idx, right_idx;
   logic [AddrWidth-1:0] parent_idx, ch_idx;
   logic [SizeWidth-1:0] sel_size;
   logic                 full, lo_gt, need_down, right_ok;

   assign left_idx   = {idx_ff, 1'b1};
   assign right_idx  = left_idx + IdxWidth'(1);
   assign parent_idx = (idx_ff - AddrWidth'(1)) >> 1;
   assign sel_size   = sel_ff ? lo_size_ff : hi_size_ff;
   assign right_ok   = right_idx < IdxWidth'(sel_size);
   assign full       = (lo_size_ff == Cap) && (hi_size_ff == Cap);
   assign lo_gt      = lo_size_ff > hi_size_ff;

   // compares on the registered read data
   logic signed [SampleWidth-1:0] ch_l, ch_r, ch_best, par;
   logic                          pick_r, dn_swap, up_swap;

   assign ch_l    = sel_ff ? lo_ra_ff : hi_ra_ff;
   assign ch_r    = sel_ff ? lo_rb_ff : hi_rb_ff;
   assign pick_r  = has_r_ff && outranks(ch_r, ch_l, sel_ff);
   assign ch_best = pick_r ? ch_r : ch_l;
   assign ch_idx  = pick_r ? right_idx[AddrWidth-1:0] : left_idx[AddrWidth-1:0];
   assign dn_swap = outranks(ch_best, cur_ff, sel_ff);
   assign par     = ch_l;
   assign up_swap = outranks(cur_ff, par, sel_ff);

   // does the sample land on the wrong side (tops read at load)
   always_comb begin
      if (lo_size_ff == '0)
         need_down = 1'b0;
      else if (lo_gt)
         need_down = lo_ra_ff > val_ff;
      else
         need_down = (hi_size_ff != '0) && (val_ff > hi_ra_ff);
   end

   // read addresses, same pair for both memories
   logic                 rd_en;
   logic [AddrWidth-1:0] ra, rb;

   assign rd_en = cmd.load | cmd.dn_read | cmd.up_read | cmd.tops_read;

   always_comb begin
      ra = '0;
      rb = '0;
      if (cmd.dn_read) begin
         ra = left_idx[AddrWidth-1:0];
         rb = right_ok ? right_idx[AddrWidth-1:0] : left_idx[AddrWidth-1:0];
      end else if (cmd.up_read) begin
         ra = parent_idx;
      end
   end

   // single write port per heap, always at the hole
   logic                          wr_en, we_lo, we_hi;
   logic signed [SampleWidth-1:0] wd;

   assign wr_en = cmd.place | cmd.dn_step | cmd.up_step;
   assign we_lo = wr_en && sel_ff;
   assign we_hi = wr_en && !sel_ff;

   always_comb begin
      if (cmd.dn_step && dn_swap)      wd = ch_best;
      else if (cmd.up_step && up_swap) wd = par;
      else                             wd = cur_ff;
   end

   // heap memories
   always_ff @(posedge clock) begin
      if (we_lo) lo_mem[idx_ff] <= wd;
      if (we_hi) hi_mem[idx_ff] <= wd;
      if (rd_en) begin
         lo_ra_ff <= lo_mem[ra];
         lo_rb_ff <= lo_mem[rb];
         hi_ra_ff <= hi_mem[ra];
         hi_rb_ff <= hi_mem[rb];
      end
   end

   // sift control next values
   always_comb begin
      lo_size_in = lo_size_ff;
      hi_size_in = hi_size_ff;
      moved_in   = moved_ff;
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      sel_in     = sel_ff;
      drop_in    = drop_ff;
      if (cmd.decide) begin
         drop_in = full;
         if (!full) begin
            cur_in = val_ff;
            if (need_down) begin
               // sample replaces the top, that top crosses over later
               sel_in   = lo_gt;
               idx_in   = '0;
               moved_in = lo_gt ? lo_ra_ff : hi_ra_ff;
            end else begin
               // append the sample at the tail of the receiving heap
               sel_in = !lo_gt;
               if (lo_gt) begin
                  idx_in     = hi_size_ff[AddrWidth-1:0];
                  hi_size_in = hi_size_ff + SizeWidth'(1);
               end else begin
                  idx_in     = lo_size_ff[AddrWidth-1:0];
                  lo_size_in = lo_size_ff + SizeWidth'(1);
               end
            end
         end
      end
      if (cmd.push) begin
         // crossing top goes to the tail of the other heap
         sel_in = !sel_ff;
         cur_in = moved_ff;
         if (sel_ff) begin
            idx_in     = hi_size_ff[AddrWidth-1:0];
            hi_size_in = hi_size_ff + SizeWidth'(1);
         end else begin
            idx_in     = lo_size_ff[AddrWidth-1:0];
            lo_size_in = lo_size_ff + SizeWidth'(1);
         end
      end
      if (cmd.dn_step && dn_swap) idx_in = ch_idx;
      if (cmd.up_step && up_swap) idx_in = parent_idx;
   end

   // heap sizes
   always_ff @(posedge clock) begin
      if (reset) begin
         lo_size_ff <= '0;
         hi_size_ff <= '0;
      end else begin
         lo_size_ff <= lo_size_in;
         hi_size_ff <= hi_size_in;
      end
   end

   // sift registers
   always_ff @(posedge clock) begin
      if (cmd.load)    val_ff   <= sample;
      if (cmd.dn_read) has_r_ff <= right_ok;
      moved_ff <= moved_in;
      cur_ff   <= cur_in;
      idx_ff   <= idx_in;
      sel_ff   <= sel_in;
      drop_ff  <= drop_in;
   end

   // result: the tops were read in the tops state
   logic signed [rmth_pkg::MedianWidth-1:0] lo_ext, hi_ext, med_in;

   assign lo_ext = rmth_pkg::MedianWidth'(lo_ra_ff);
   assign hi_ext = rmth_pkg::MedianWidth'(hi_ra_ff);
   assign med_in = (lo_size_ff == hi_size_ff) ? lo_ext + hi_ext : lo_ext <<< 1;

   always_ff @(posedge clock) begin
      if (cmd.result) begin
         med_ff     <= med_in;
         cnt_ff     <= rmth_pkg::CountWidth'(lo_size_ff)
                       + rmth_pkg::CountWidth'(hi_size_ff);
         dropped_ff <= drop_ff;
      end
   end

   assign median_doubled   = med_ff;
   assign held_count       = cnt_ff;
   assign dropped          = dropped_ff;
   assign status.full      = full;
   assign status.need_down = need_down;
   assign status.leaf      = left_idx >= IdxWidth'(sel_size);
   assign status.at_root   = (idx_ff == '0);
   assign status.dn_stop   = !dn_swap;
   assign status.up_stop   = !up_swap;

   // lower heap never smaller, never more than one larger
   a_balance: assert property (@(posedge clock) disable iff (reset)
      cmd.result |-> (lo_size_ff == hi_size_ff ||
                      lo_size_ff == hi_size_ff + SizeWidth'(1)))
      else $error("heaps unbalanced");
   // sizes never exceed capacity
   a_cap: assert property (@(posedge clock) disable iff (reset)
      lo_size_ff <= Cap && hi_size_ff <= Cap)
      else $error("heap overflow");
   // a dropped item leaves the sizes unchanged
   a_drop: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && full) |=> $stable(lo_size_ff) && $stable(hi_size_ff))
      else $error("size changed on drop");
   // writes stay inside the live part of a heap
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> SizeWidth'(idx_ff) < sel_size)
      else $error("write beyond heap size");

endmodule

// File: sv/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps: running median over two heaps
// Lower half in a max-heap, upper half in a min-heap; reports twice the
// median, the held count and a drop flag for every item.
//
//   channel   dir   payload
//   req       in    sample[31:0]
//   rsp       out   median_doubled[32:0], held_count[10:0], dropped
//
// Each sift level has a read state and a compare/write state, as the heap
// reads are registered. A plain append only sifts up; when a top crosses
// over, the sample first sifts down from the replaced top, then the crossing
// top is pushed and sifts up; a dropped item skips the sifts.
// Reset clears the heap sizes; heap contents need no clearing.
// A stalled result holds in its register; the next item may be worked on
// meanwhile but waits in its last state until the register frees.
// ----------------------------------------------------------------------------
module running_median_two_heaps #(
   parameter int HalfCapacity = rmth_pkg::HalfCapacityDefault,
   parameter int SampleWidth  = rmth_pkg::SampleWidthDefault
) (
   input  logic               clock,
   input  logic               reset,
   rmth_stream_if.sink        req_chan,
   rmth_stream_if.source      rsp_chan
);

   rmth_pkg::cmd_type    cmd;
   rmth_pkg::status_type status;
   logic signed [rmth_pkg::MedianWidth-1:0] median_doubled;
   logic [rmth_pkg::CountWidth-1:0]         held_count;
   logic                                    dropped;

   rmth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   rmth_datapath #(
      .HalfCapacity (HalfCapacity),
      .SampleWidth  (SampleWidth)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .sample         (req_chan.data[SampleWidth-1:0]),
      .cmd            (cmd),
      .status         (status),
      .median_doubled (median_doubled),
      .held_count     (held_count),
      .dropped        (dropped)
   );

   assign rsp_chan.data = {median_doubled, held_count, dropped};

endmodule

// File: tb/running_median_two_heaps_tb.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_tb: self-checking bench for the running median
// Sends signed samples through the req channel and checks each rsp item:
// the doubled median, the held count and the drop flag. The store is filled
// past its capacity so that drops are seen. Both channels idle in bursts.
// ----------------------------------------------------------------------------
module running_median_two_heaps_tb;

   localparam int HalfCap   = rmth_pkg::HalfCapacityDefault;
   localparam int RspWidth  = rmth_pkg::MedianWidth + rmth_pkg::CountWidth + 1;
   localparam int NumRandom = 1130;
   localparam int CalmItems = 100;
   localparam int Watchdog  = 4000;
   localparam int DrainWait = 100;

   typedef struct {
      logic signed [rmth_pkg::MedianWidth-1:0] median_doubled;
      logic [rmth_pkg::CountWidth-1:0]         held_count;
      logic                                    dropped;
   } median_rsp_type;

   typedef struct {
      logic [rmth_pkg::DataWidth-1:0]          sample;
      bit                                      typed;
      logic signed [rmth_pkg::MedianWidth-1:0] median_doubled;
      logic [rmth_pkg::CountWidth-1:0]         held_count;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmth_stream_if #(.Width(rmth_pkg::DataWidth)) req_chan ();
   rmth_stream_if #(.Width(RspWidth))            rsp_chan ();

   running_median_two_heaps dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #2 clock = ~clock;

   // predictor state: every held sample, kept in ascending order
   int             held_sorted[$];
   median_rsp_type pending_medians[$];
   int             errors;
   int             idle_cycles;
   int             drops_seen;
   int             rsp_seen;
   bit             calm;

   // add one sample to the predicted set and give the expected result
   function automatic median_rsp_type insert_and_median(
         logic [rmth_pkg::DataWidth-1:0] raw);
      median_rsp_type r;
      int             v;
      int             pos;
      int             n;
      longint         m2;
      v = $signed(raw);
      r.dropped = 1'b0;
      if (held_sorted.size() >= 2 * HalfCap) begin
         r.dropped = 1'b1;
      end else begin
         pos = 0;
         while (pos < held_sorted.size() && held_sorted[pos] <= v) pos++;
         held_sorted.insert(pos, v);
      end
      n = held_sorted.size();
      if (n % 2 == 1) m2 = 2 * longint'(held_sorted[(n - 1) / 2]);
      else m2 = longint'(held_sorted[n / 2 - 1]) + longint'(held_sorted[n / 2]);
      r.median_doubled = m2[rmth_pkg::MedianWidth-1:0];
      r.held_count     = n[rmth_pkg::CountWidth-1:0];
      return r;
   endfunction

   // random sample: full range, extremes, narrow band, or repeats
   function automatic logic [rmth_pkg::DataWidth-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0:       return 32'h7fff_ffff - $urandom_range(0, 3);
         1:       return 32'h8000_0000 + $urandom_range(0, 3);
         2:       return $urandom_range(0, 40) - 20;
         3:       return held_sorted.size() ? held_sorted[$urandom_range(0,
                     held_sorted.size() - 1)] : $urandom;
         default: return $urandom;
      endcase
   endfunction

   // result side: random stall bursts, none in the calm tail
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else if (stall_left > 0) begin
         stall_left     <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left     <= $urandom_range(1, 14) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      logic [RspWidth-1:0] d;
      median_rsp_type      e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         d = rsp_chan.data;
         rsp_seen++;
         if (pending_medians.size() == 0) begin
            $error("rsp item with no expectation waiting");
            errors++;
         end else begin
            e = pending_medians.pop_front();
            if (d[RspWidth-1 -: rmth_pkg::MedianWidth] !== e.median_doubled) begin
               $error("median_doubled expected %0d actual %0d", e.median_doubled,
                  $signed(d[RspWidth-1 -: rmth_pkg::MedianWidth]));
               errors++;
            end
            if (d[rmth_pkg::CountWidth:1] !== e.held_count) begin
               $error("held_count expected %0d actual %0d", e.held_count,
                  d[rmth_pkg::CountWidth:1]);
               errors++;
            end
            if (d[0] !== e.dropped) begin
               $error("dropped expected %0d actual %0d", e.dropped, d[0]);
               errors++;
            end
            if (e.dropped) drops_seen++;
         end
      end
   end

   // watchdog on cycles with no accepted item on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready)
            || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= Watchdog) begin
            $display("watchdog: no item accepted for %0d cycles", Watchdog);
            $display("FAIL running_median_two_heaps");
            $finish;
         end
      end
   end

   // send one item, with a random gap ahead of it
   task automatic send_sample(logic [rmth_pkg::DataWidth-1:0] s,
                              output median_rsp_type pred);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 14);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= s;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      pred = insert_and_median(s);
   endtask

   // most negative doubled median is the 33-bit pattern 1_0000_0000
   stim_row_type directed[] = '{
      '{32'h7fff_ffff, 1, 33'sd4294967294,   11'd1},
      '{32'h8000_0000, 1, -33'sd1,           11'd2},
      '{32'h8000_0000, 1, 33'sh1_0000_0000,  11'd3},
      '{32'h7fff_ffff, 0, '0, '0},
      '{32'h7fff_ffff, 0, '0, '0},
      '{32'h0000_0000, 0, '0, '0},
      '{32'hffff_ffff, 0, '0, '0},
      '{32'h0000_0001, 0, '0, '0},
      '{32'h5555_5555, 0, '0, '0},
      '{32'haaaa_aaaa, 0, '0, '0},
      '{32'h0000_0000, 0, '0, '0},
      '{32'h0000_0000, 0, '0, '0},
      '{32'hffff_fffe, 0, '0, '0},
      '{32'h0000_0064, 0, '0, '0},
      '{32'hffff_ff9c, 0, '0, '0},
      '{32'h8000_0001, 0, '0, '0},
      '{32'h7fff_fffe, 0, '0, '0},
      '{32'h0000_0002, 0, '0, '0}
   };

   initial begin
      median_rsp_type pred;
      errors = 0; drops_seen = 0; rsp_seen = 0; calm = 0;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows; typed results where they are plain to see
      foreach (directed[i]) begin
         send_sample(directed[i].sample, pred);
         if (directed[i].typed) begin
            pred.median_doubled = directed[i].median_doubled;
            pred.held_count     = directed[i].held_count;
            pred.dropped        = 1'b0;
         end
         pending_medians = {pending_medians, pred};
      end

      // random items; the store fills and later samples are dropped
      for (int k = 0; k < NumRandom; k++) begin
         if (k >= NumRandom - CalmItems) calm = 1;
         send_sample(pick_sample(), pred);
         pending_medians = {pending_medians, pred};
      end
      req_chan.valid <= 1'b0;

      while (pending_medians.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      $display("covered %0d results, %0d of them dropped on a full store",
         rsp_seen, drops_seen);
      if (errors == 0) begin
         $display("PASS running_median_two_heaps");
      end else begin
         $display("FAIL running_median_two_heaps");
      end
      $finish;
   end
endmodule

// File: sim.f
sv/rmth_pkg.sv
sv/rmth_stream_if.sv
sv/rmth_ctrl.sv
sv/rmth_datapath.sv
sv/running_median_two_heaps.sv
tb/running_median_two_heaps_tb.sv
